// ===== design/rws_pkg.sv =====
// Package for the recording window scheduler.
// Holds the channel payload types, the decoded item and configuration types and the codes.
// No dependencies.
package rws_pkg;

   localparam int RUNS_BITS      = 10;
   localparam int WINDOW_BITS    = 20;
   localparam int STAMP_BITS     = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = 1;

   localparam logic [RUNS_BITS-1:0] RUNS_SAT = 10'd1023;

   typedef enum logic [1:0] {
      REQ_TICK   = 2'd0,
      REQ_ARM    = 2'd1,
      REQ_CANCEL = 2'd2,
      REQ_IGNORE = 2'd3
   } rws_op_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_WAIT = 2'd1,
      PH_REC  = 2'd2
   } rws_phase_type;

   typedef enum logic [1:0] {
      MODE_NONE  = 2'd0,
      MODE_FIXED = 2'd1,
      MODE_GAP   = 2'd2
   } rws_mode_type;

   typedef enum logic [2:0] {
      EV_NONE        = 3'd0,
      EV_STARTED     = 3'd1,
      EV_START_FAIL  = 3'd2,
      EV_STOP_FAIL   = 3'd3,
      EV_NEXT        = 3'd4,
      EV_COMPLETED   = 3'd5,
      EV_CANCELED    = 3'd6,
      EV_ARMED       = 3'd7
   } rws_event_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SCHED_MODE      = 3'd0,
      CSR_WINDOW_SECONDS  = 3'd1,
      CSR_GAP_SECONDS     = 3'd2,
      CSR_COUNT_LIMIT_ON  = 3'd3,
      CSR_RUN_LIMIT       = 3'd4,
      CSR_FIRST_START     = 3'd5,
      CSR_FIRST_START_SET = 3'd6
   } rws_csr_index_type;

   typedef struct packed {
      logic [1:0]            req_type;
      logic [STAMP_BITS-1:0] now_seconds;
      logic                  start_ok;
      logic                  stop_ok;
      logic                  session_open;
   } rws_req_type;

   typedef struct packed {
      logic [1:0]            phase_now;
      logic [2:0]            event_code;
      logic                  start_request;
      logic                  stop_request;
      logic [RUNS_BITS-1:0]  runs_done;
      logic [STAMP_BITS-1:0] next_start_out;
      logic [STAMP_BITS-1:0] stop_at_out;
   } rws_rsp_type;

   typedef struct packed {
      rws_op_type            op;
      logic [STAMP_BITS-1:0] now_seconds;
      logic                  start_ok;
      logic                  stop_ok;
      logic                  session_open;
   } rws_item_type;

   typedef struct packed {
      logic                  valid;
      logic                  full;
   } rws_queue_status_type;

   typedef struct packed {
      logic [1:0]             sched_mode;
      logic [WINDOW_BITS-1:0] window_seconds;
      logic [WINDOW_BITS-1:0] gap_seconds;
      logic                   count_limit_on;
      logic [RUNS_BITS-1:0]   run_limit;
      logic [STAMP_BITS-1:0]  first_start;
      logic                   first_start_set;
   } rws_cfg_type;

endpackage

// ===== design/recording_window_scheduler_unit.sv =====
// Top level of the recording window scheduler: configuration registers and the three parts.
// Depends on rws_pkg, rws_front, rws_queue and rws_back.
//
//   Port group  Direction  Handshake            Payload
//   req_        in         req_valid/req_stall  rws_req_type
//   rsp_        out        rsp_valid/rsp_stall  rws_rsp_type
//   csr_        in         csr_wr_en            csr_index, csr_wdata
//
// A request is accepted each cycle req_stall is low; its response is registered after the queue.
// The rate is one item per cycle, set by the back-end state update, unless a response stalls.
// Reset is synchronous and returns the schedule to idle with registers at their defaults.
// A stalled response holds; up to two further requests wait in the queue before req_stall rises.
module recording_window_scheduler_unit #(
   parameter int TIME_BITS = 32,
   parameter int MAX_RUNS  = 999
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  rws_pkg::rws_req_type                 req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rws_pkg::rws_rsp_type                 rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [rws_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [rws_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import rws_pkg::*;

   rws_cfg_type          cfg_ff, cfg_in;
   rws_queue_status_type q_status;
   rws_item_type         push_item, head_item;
   logic                 push, pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SCHED_MODE:      cfg_in.sched_mode      = csr_wdata[1:0];
            CSR_WINDOW_SECONDS:  cfg_in.window_seconds  = csr_wdata[WINDOW_BITS-1:0];
            CSR_GAP_SECONDS:     cfg_in.gap_seconds     = csr_wdata[WINDOW_BITS-1:0];
            CSR_COUNT_LIMIT_ON:  cfg_in.count_limit_on  = csr_wdata[0];
            CSR_RUN_LIMIT:       cfg_in.run_limit       = csr_wdata[RUNS_BITS-1:0];
            CSR_FIRST_START:     cfg_in.first_start     = csr_wdata[STAMP_BITS-1:0];
            CSR_FIRST_START_SET: cfg_in.first_start_set = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sched_mode      <= MODE_NONE;
         cfg_ff.window_seconds  <= WINDOW_BITS'(1);
         cfg_ff.gap_seconds     <= WINDOW_BITS'(1);
         cfg_ff.count_limit_on  <= 1'b0;
         cfg_ff.run_limit       <= RUNS_BITS'(1);
         cfg_ff.first_start     <= '0;
         cfg_ff.first_start_set <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rws_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   rws_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   rws_back #(
      .TIME_BITS (TIME_BITS),
      .MAX_RUNS  (MAX_RUNS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_item (head_item),
      .q_status  (q_status),
      .pop       (pop),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   a_started_records: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_code == EV_STARTED |->
         rsp_data.start_request && rsp_data.phase_now == PH_REC && rsp_data.stop_at_out != '0)
      else $error("started response without start request or recording phase");

   a_completed_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_code == EV_COMPLETED |->
         rsp_data.phase_now == PH_IDLE && rsp_data.runs_done == '0)
      else $error("completed response left the schedule active");

   a_stop_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stop_request |->
         rsp_data.event_code == EV_STOP_FAIL || rsp_data.event_code == EV_NEXT ||
         rsp_data.event_code == EV_COMPLETED)
      else $error("stop request with an unrelated event");

   a_queue_full_stalls: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> req_stall && !push)
      else $error("request transfer taken while the queue is full");
`endif

endmodule

// ===== design/rws_front.sv =====
// Front end of the recording window scheduler: accepts request transfers and decodes them.
// Depends on rws_pkg; feeds rws_queue.
module rws_front (
   input  logic                          req_valid,
   output logic                          req_stall,
   input  rws_pkg::rws_req_type          req_data,
   input  rws_pkg::rws_queue_status_type q_status,
   output logic                          push,
   output rws_pkg::rws_item_type         push_item
);
   import rws_pkg::*;

   rws_op_type op;

   always_comb begin
      unique case (req_data.req_type)
         2'd0:    op = REQ_TICK;
         2'd1:    op = REQ_ARM;
         2'd2:    op = REQ_CANCEL;
         default: op = REQ_IGNORE;
      endcase
   end

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   always_comb begin
      push_item.op           = op;
      push_item.now_seconds  = req_data.now_seconds;
      push_item.start_ok     = req_data.start_ok;
      push_item.stop_ok      = req_data.stop_ok;
      push_item.session_open = req_data.session_open;
   end

endmodule

// ===== design/rws_queue.sv =====
// Short queue between the front end and the back end of the scheduler.
// Depends on rws_pkg for the item type and the queue depth.
module rws_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  rws_pkg::rws_item_type         push_item,
   input  logic                          pop,
   output rws_pkg::rws_item_type         head_item,
   output rws_pkg::rws_queue_status_type q_status
);
   import rws_pkg::*;

   rws_item_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item      = entries_ff[rd_ptr_ff];
   assign q_status.valid = count_ff != '0;
   assign q_status.full  = count_ff == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH);

endmodule

// ===== design/rws_back.sv =====
// Back end of the scheduler: schedule state, time compares and the result register.
// Depends on rws_pkg; takes items from rws_queue and configuration from the top level.
module rws_back #(
   parameter int TIME_BITS = 32,
   parameter int MAX_RUNS  = 999
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rws_pkg::rws_item_type         head_item,
   input  rws_pkg::rws_queue_status_type q_status,
   output logic                          pop,
   input  rws_pkg::rws_cfg_type          cfg,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rws_pkg::rws_rsp_type          rsp_data
);
   import rws_pkg::*;

   localparam int SUM_W = ((TIME_BITS > WINDOW_BITS) ? TIME_BITS : WINDOW_BITS) + 1;
   localparam logic [RUNS_BITS-1:0] MAX_RUNS_V = RUNS_BITS'(MAX_RUNS);

   rws_phase_type            phase_ff, phase_in;
   logic [TIME_BITS-1:0]     next_start_ff, next_start_in;
   logic [TIME_BITS-1:0]     stop_at_ff, stop_at_in;
   logic [RUNS_BITS-1:0]     runs_ff, runs_in;
   logic                     seen_ff, seen_in;
   rws_mode_type             mode_ff, mode_in;
   logic [WINDOW_BITS-1:0]   window_ff, window_in;
   logic [WINDOW_BITS-1:0]   gap_ff, gap_in;
   logic                     limit_on_ff, limit_on_in;
   logic [RUNS_BITS-1:0]     limit_ff, limit_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rws_rsp_type              rsp_ff, rsp_in;

   rws_event_type            ev;
   logic                     start_req, stop_req, do_finish, round_end;
   logic [TIME_BITS+STAMP_BITS-1:0] now_ext, first_ext;
   logic [TIME_BITS-1:0]     now_t, first_t;
   logic [SUM_W-1:0]         win_sum, gap_sum;
   logic [TIME_BITS-1:0]     win_sat, gap_sat;
   logic [RUNS_BITS-1:0]     runs_inc;
   logic [TIME_BITS+STAMP_BITS-1:0] next_wide, stop_wide;

   assign now_ext   = {{TIME_BITS{1'b0}}, head_item.now_seconds};
   assign first_ext = {{TIME_BITS{1'b0}}, cfg.first_start};
   assign now_t     = now_ext[TIME_BITS-1:0];
   assign first_t   = first_ext[TIME_BITS-1:0];

   assign win_sum = SUM_W'(now_t) + SUM_W'(window_ff);
   assign gap_sum = SUM_W'(now_t) + SUM_W'(gap_ff);
   assign win_sat = (|win_sum[SUM_W-1:TIME_BITS]) ? '1 : win_sum[TIME_BITS-1:0];
   assign gap_sat = (|gap_sum[SUM_W-1:TIME_BITS]) ? '1 : gap_sum[TIME_BITS-1:0];

   assign runs_inc  = (runs_ff != RUNS_SAT) ? runs_ff + 1'b1 : runs_ff;
   assign round_end = (mode_ff == MODE_FIXED) || (limit_on_ff && (runs_inc >= limit_ff));

   assign pop = q_status.valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      phase_in      = phase_ff;
      next_start_in = next_start_ff;
      stop_at_in    = stop_at_ff;
      runs_in       = runs_ff;
      seen_in       = seen_ff;
      mode_in       = mode_ff;
      window_in     = window_ff;
      gap_in        = gap_ff;
      limit_on_in   = limit_on_ff;
      limit_in      = limit_ff;
      ev            = EV_NONE;
      start_req     = 1'b0;
      stop_req      = 1'b0;
      do_finish     = 1'b0;
      case (head_item.op)
         REQ_ARM: begin
            if (cfg.sched_mode == MODE_FIXED || cfg.sched_mode == MODE_GAP) begin
               mode_in       = rws_mode_type'(cfg.sched_mode);
               phase_in      = PH_WAIT;
               window_in     = (cfg.window_seconds == '0) ? WINDOW_BITS'(1) : cfg.window_seconds;
               gap_in        = (cfg.gap_seconds == '0) ? WINDOW_BITS'(1) : cfg.gap_seconds;
               limit_on_in   = cfg.count_limit_on;
               limit_in      = (cfg.run_limit == '0) ? RUNS_BITS'(1) :
                               ((cfg.run_limit > MAX_RUNS_V) ? MAX_RUNS_V : cfg.run_limit);
               runs_in       = '0;
               next_start_in = cfg.first_start_set ? first_t : now_t;
               stop_at_in    = '0;
               seen_in       = 1'b0;
               ev            = EV_ARMED;
            end else begin
               mode_in       = MODE_NONE;
               phase_in      = PH_IDLE;
               next_start_in = '0;
               stop_at_in    = '0;
               runs_in       = '0;
               seen_in       = 1'b0;
               ev            = EV_CANCELED;
            end
         end
         REQ_CANCEL: begin
            mode_in       = MODE_NONE;
            phase_in      = PH_IDLE;
            next_start_in = '0;
            stop_at_in    = '0;
            runs_in       = '0;
            seen_in       = 1'b0;
            ev            = EV_CANCELED;
         end
         REQ_TICK: begin
            if (mode_ff != MODE_NONE) begin
               if (phase_ff == PH_WAIT) begin
                  if (now_t >= next_start_ff) begin
                     start_req = 1'b1;
                     if (head_item.start_ok) begin
                        phase_in   = PH_REC;
                        stop_at_in = win_sat;
                        seen_in    = head_item.session_open;
                        ev         = EV_STARTED;
                     end else if (mode_ff == MODE_FIXED) begin
                        mode_in       = MODE_NONE;
                        phase_in      = PH_IDLE;
                        next_start_in = '0;
                        stop_at_in    = '0;
                        runs_in       = '0;
                        seen_in       = 1'b0;
                        ev            = EV_START_FAIL;
                     end else begin
                        phase_in      = PH_WAIT;
                        next_start_in = gap_sat;
                        stop_at_in    = '0;
                        seen_in       = 1'b0;
                        ev            = EV_START_FAIL;
                     end
                  end
               end else if (phase_ff == PH_REC) begin
                  if (!head_item.session_open && seen_ff) begin
                     do_finish = 1'b1;
                  end else begin
                     if (head_item.session_open) begin
                        seen_in = 1'b1;
                     end
                     if (now_t >= stop_at_ff) begin
                        stop_req = 1'b1;
                        if (head_item.stop_ok) begin
                           do_finish = 1'b1;
                        end else begin
                           ev = EV_STOP_FAIL;
                        end
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase
      if (do_finish) begin
         if (round_end) begin
            mode_in       = MODE_NONE;
            phase_in      = PH_IDLE;
            next_start_in = '0;
            stop_at_in    = '0;
            runs_in       = '0;
            seen_in       = 1'b0;
            ev            = EV_COMPLETED;
         end else begin
            runs_in       = runs_inc;
            phase_in      = PH_WAIT;
            next_start_in = gap_sat;
            stop_at_in    = '0;
            seen_in       = 1'b0;
            ev            = EV_NEXT;
         end
      end
   end

   assign next_wide = {{STAMP_BITS{1'b0}}, next_start_in};
   assign stop_wide = {{STAMP_BITS{1'b0}}, stop_at_in};

   always_comb begin
      rsp_in.phase_now      = phase_in;
      rsp_in.event_code     = ev;
      rsp_in.start_request  = start_req;
      rsp_in.stop_request   = stop_req;
      rsp_in.runs_done      = runs_in;
      rsp_in.next_start_out = (phase_in == PH_WAIT) ? next_wide[STAMP_BITS-1:0] : '0;
      rsp_in.stop_at_out    = (phase_in == PH_REC) ? stop_wide[STAMP_BITS-1:0] : '0;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         next_start_ff <= '0;
         stop_at_ff    <= '0;
         runs_ff       <= '0;
         seen_ff       <= 1'b0;
         mode_ff       <= MODE_NONE;
         window_ff     <= WINDOW_BITS'(1);
         gap_ff        <= WINDOW_BITS'(1);
         limit_on_ff   <= 1'b0;
         limit_ff      <= RUNS_BITS'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff      <= phase_in;
            next_start_ff <= next_start_in;
            stop_at_ff    <= stop_at_in;
            runs_ff       <= runs_in;
            seen_ff       <= seen_in;
            mode_ff       <= mode_in;
            window_ff     <= window_in;
            gap_ff        <= gap_in;
            limit_on_ff   <= limit_on_in;
            limit_ff      <= limit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
